/* design/wfg_pkg.sv */
// wfg_pkg: shared types, codes and constants of the wait-for graph cycle detector
// used by wfg_ctrl, wfg_dp and the top level; depends on nothing

package wfg_pkg;

  // field widths of the request and the configuration register
  localparam int unsigned MODE_W = 2;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned CFG_W  = 7;

  // default graph capacity and reset node count
  localparam int unsigned MAX_NODES_DEF  = 64;
  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  // request modes (code 3 is unused and rejected)
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_CHECK = 2'd2
  } mode_e;

  // request payload
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } req_t;

  // response payload
  typedef struct packed {
    logic status;
    logic cycle_found;
  } rsp_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic clear_rows;
    logic add_write;
    logic chk_init;
    logic root_push;
    logic cursor_inc;
    logic row_load;
    logic next_inc;
    logic node_push;
    logic node_pop;
    logic frame_load;
    logic out_load;
    logic out_status;
    logic out_cycle;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic add_ok;
    logic scan_done;
    logic start_white;
    logic next_end;
    logic edge_hit;
    logic hit_gray;
    logic stack_empty;
    logic out_free;
  } sts_t;

endpackage

/* design/wfg_ram.sv */
// wfg_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing

module wfg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/wfg_dp.sv */
// wfg_dp: datapath of the cycle detector: adjacency ram with row valid bits,
// search stack ram, node colors, search registers and output register
// depends on wfg_pkg and wfg_ram

module wfg_dp
  import wfg_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  req_t             in_req_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output rsp_t             out_rsp_o,
  input  cmd_t             cmd_i,
  output sts_t             sts_o
);

  localparam int unsigned IDX_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned FR_W  = IDX_W + CNT_W;

  // configuration and nodes in use
  logic [CFG_W-1:0] node_count_q;
  logic [CNT_W-1:0] n_use;

  // adjacency store
  logic [MAX_NODES-1:0] row_vld_q;
  logic                 adj_vld_q;
  logic [IDX_W-1:0]     adj_raddr;
  logic [MAX_NODES-1:0] adj_rdata;
  logic [MAX_NODES-1:0] adj_row;
  logic [MAX_NODES-1:0] adj_wdata;
  logic [IDX_W-1:0]     from_q;
  logic [IDX_W-1:0]     to_q;

  // search state
  logic [MAX_NODES-1:0] gray_q;
  logic [MAX_NODES-1:0] black_q;
  logic [CNT_W-1:0]     cursor_q;
  logic [CNT_W-1:0]     sp_q;
  logic [IDX_W-1:0]     cur_node_q;
  logic [CNT_W-1:0]     cur_next_q;
  logic [MAX_NODES-1:0] cur_row_q;
  logic [IDX_W-1:0]     cursor_idx;
  logic [IDX_W-1:0]     next_idx;

  // stack store
  logic [FR_W-1:0]  stk_wdata;
  logic [FR_W-1:0]  stk_rdata;
  logic [IDX_W-1:0] stk_waddr;
  logic [IDX_W-1:0] stk_raddr;
  logic [IDX_W-1:0] frame_node;
  logic [CNT_W-1:0] frame_next;

  // output register
  logic out_valid_q;
  rsp_t out_rsp_q;
  logic out_free;

  // node count capped at the capacity
  always_comb begin
    if (node_count_q > CFG_W'(MAX_NODES)) begin
      n_use = CNT_W'(MAX_NODES);
    end else begin
      n_use = node_count_q[CNT_W-1:0];
    end
  end

  assign cursor_idx = cursor_q[IDX_W-1:0];
  assign next_idx   = cur_next_q[IDX_W-1:0];
  assign frame_node = stk_rdata[FR_W-1 -: IDX_W];
  assign frame_next = stk_rdata[CNT_W-1:0];

  // adjacency read address: edge source, search root, pushed node or popped frame
  always_comb begin
    priority if (cmd_i.accept) begin
      adj_raddr = in_req_i.from_node[IDX_W-1:0];
    end else if (cmd_i.root_push) begin
      adj_raddr = cursor_idx;
    end else if (cmd_i.node_push) begin
      adj_raddr = next_idx;
    end else begin
      adj_raddr = frame_node;
    end
  end

  // a row never written since the last clear reads as empty
  assign adj_row   = adj_rdata & {MAX_NODES{adj_vld_q}};
  assign adj_wdata = adj_row | ({{(MAX_NODES-1){1'b0}}, 1'b1} << to_q);

  wfg_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_write),
    .waddr_i (from_q),
    .wdata_i (adj_wdata),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  // stack frames below the top: node and next neighbour to try
  assign stk_waddr = sp_q[IDX_W-1:0];
  assign stk_raddr = IDX_W'(sp_q - CNT_W'(1));
  assign stk_wdata = {cur_node_q, cur_next_q + CNT_W'(1)};

  wfg_ram #(
    .WIDTH (FR_W),
    .DEPTH (MAX_NODES)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.node_push),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // status toward the controller
  always_comb begin
    sts_o.mode        = in_req_i.mode;
    sts_o.add_ok      = (CFG_W'(in_req_i.from_node) < CFG_W'(n_use)) &&
                        (CFG_W'(in_req_i.to_node) < CFG_W'(n_use));
    sts_o.scan_done   = (cursor_q == n_use);
    sts_o.start_white = !gray_q[cursor_idx] && !black_q[cursor_idx];
    sts_o.next_end    = (cur_next_q >= n_use);
    sts_o.edge_hit    = cur_row_q[next_idx] && !black_q[next_idx];
    sts_o.hit_gray    = gray_q[next_idx];
    sts_o.stack_empty = (sp_q == '0);
    sts_o.out_free    = out_free;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      row_vld_q    <= '0;
      gray_q       <= '0;
      black_q      <= '0;
      cursor_q     <= '0;
      sp_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      // row valid bits
      if (cmd_i.clear_rows) begin
        row_vld_q <= '0;
      end else if (cmd_i.add_write) begin
        row_vld_q[from_q] <= 1'b1;
      end
      // search start
      if (cmd_i.chk_init) begin
        gray_q   <= '0;
        black_q  <= '0;
        cursor_q <= '0;
        sp_q     <= '0;
      end
      if (cmd_i.cursor_inc) begin
        cursor_q <= cursor_q + CNT_W'(1);
      end
      if (cmd_i.root_push) begin
        gray_q[cursor_idx] <= 1'b1;
      end
      // descend into a white neighbour
      if (cmd_i.node_push) begin
        gray_q[next_idx] <= 1'b1;
        sp_q             <= sp_q + CNT_W'(1);
      end
      // finish the top node
      if (cmd_i.node_pop) begin
        gray_q[cur_node_q]  <= 1'b0;
        black_q[cur_node_q] <= 1'b1;
        if (sp_q != '0) begin
          sp_q <= sp_q - CNT_W'(1);
        end
      end
      // output register
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    adj_vld_q <= row_vld_q[adj_raddr];
    if (cmd_i.accept) begin
      from_q <= in_req_i.from_node[IDX_W-1:0];
      to_q   <= in_req_i.to_node[IDX_W-1:0];
    end
    if (cmd_i.root_push) begin
      cur_node_q <= cursor_idx;
      cur_next_q <= '0;
    end else if (cmd_i.node_push) begin
      cur_node_q <= next_idx;
      cur_next_q <= '0;
    end else if (cmd_i.frame_load) begin
      cur_node_q <= frame_node;
      cur_next_q <= frame_next;
    end else if (cmd_i.next_inc) begin
      cur_next_q <= cur_next_q + CNT_W'(1);
    end
    if (cmd_i.row_load) begin
      cur_row_q <= adj_row;
    end
    if (cmd_i.out_load) begin
      out_rsp_q.status      <= cmd_i.out_status;
      out_rsp_q.cycle_found <= cmd_i.out_cycle;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // a waiting response is never overwritten
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("response loaded while the previous one is still held");

  // a node is never both on the stack and finished
  a_color_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gray_q & black_q) == '0)
    else $error("node marked both on stack and finished");

  // the saved frames always fit the stack
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.node_push |-> (sp_q < CNT_W'(MAX_NODES - 1)))
    else $error("search stack overflow");

endmodule

/* design/wfg_ctrl.sv */
// wfg_ctrl: controller state machine of the cycle detector, sequences edge adds,
// clears and the depth-first search; depends on wfg_pkg

module wfg_ctrl
  import wfg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WR,
    S_SCAN,
    S_LOAD,
    S_STEP,
    S_POP,
    S_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   pend_status_q, pend_status_d;
  logic   pend_cycle_q, pend_cycle_d;
  logic   fin;
  logic   fin_status;
  logic   fin_cycle;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d       = state_q;
    pend_status_d = pend_status_q;
    pend_cycle_d  = pend_cycle_q;
    cmd_o         = '0;
    fin           = 1'b0;
    fin_status    = 1'b0;
    fin_cycle     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (mode_e'(sts_i.mode))
            MODE_ADD: begin
              if (sts_i.add_ok) begin
                state_d = S_ADD_WR;
              end else begin
                fin        = 1'b1;
                fin_status = 1'b1;
              end
            end
            MODE_CLEAR: begin
              cmd_o.clear_rows = 1'b1;
              fin              = 1'b1;
            end
            MODE_CHECK: begin
              cmd_o.chk_init = 1'b1;
              state_d        = S_SCAN;
            end
            default: begin
              fin        = 1'b1;
              fin_status = 1'b1;
            end
          endcase
        end
      end
      // merge the new edge into the row read at accept
      S_ADD_WR: begin
        cmd_o.add_write = 1'b1;
        fin             = 1'b1;
      end
      // look for the next unvisited root
      S_SCAN: begin
        if (sts_i.scan_done) begin
          fin = 1'b1;
        end else if (sts_i.start_white) begin
          cmd_o.root_push = 1'b1;
          state_d         = S_LOAD;
        end else begin
          cmd_o.cursor_inc = 1'b1;
        end
      end
      S_LOAD: begin
        cmd_o.row_load = 1'b1;
        state_d        = S_STEP;
      end
      // test one neighbour of the top node
      S_STEP: begin
        if (sts_i.next_end) begin
          cmd_o.node_pop = 1'b1;
          state_d        = sts_i.stack_empty ? S_SCAN : S_POP;
        end else if (sts_i.edge_hit && sts_i.hit_gray) begin
          fin       = 1'b1;
          fin_cycle = 1'b1;
        end else if (sts_i.edge_hit) begin
          cmd_o.node_push = 1'b1;
          state_d         = S_LOAD;
        end else begin
          cmd_o.next_inc = 1'b1;
        end
      end
      S_POP: begin
        cmd_o.frame_load = 1'b1;
        state_d          = S_LOAD;
      end
      S_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = pend_status_q;
          cmd_o.out_cycle  = pend_cycle_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // hand the response to the output register or hold it
    if (fin) begin
      if (sts_i.out_free) begin
        cmd_o.out_load   = 1'b1;
        cmd_o.out_status = fin_status;
        cmd_o.out_cycle  = fin_cycle;
        state_d          = S_IDLE;
      end else begin
        pend_status_d = fin_status;
        pend_cycle_d  = fin_cycle;
        state_d       = S_WAIT;
      end
    end
  end

  // state and held response
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pend_status_q <= 1'b0;
      pend_cycle_q  <= 1'b0;
    end else begin
      state_q       <= state_d;
      pend_status_q <= pend_status_d;
      pend_cycle_q  <= pend_cycle_d;
    end
  end

  // a check request keeps the input stalled in the following cycle
  a_check_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (sts_i.mode == MODE_CHECK)) |=> in_stall_o)
    else $error("input not stalled after a check request");

endmodule

/* design/wait_for_graph_cycle_detector_core.sv */
// wait_for_graph_cycle_detector_core: top level of the wait-for graph cycle detector
// depends on wfg_pkg, wfg_ctrl, wfg_dp (and wfg_ram below it)
//
//   channel   valid        stall         payload       dir
//   request   in_valid_i   in_stall_o    in_req_i      in
//   response  out_valid_o  out_stall_i   out_rsp_o     out
//   config    cfg_we_i     -             cfg_wdata_i   in
//
// clear and rejected requests finish at accept; an edge add reads the row, then writes it
// a check searches the n nodes in use depth first: one neighbour is tested per cycle,
// and every push or pop costs an adjacency ram read
// reset clears the graph at once through per-row valid bits, no clearing pass
// in_stall_o is high while a request is in work; a finished response waits in the
// output register, and the next request is taken while it waits

module wait_for_graph_cycle_detector_core
  import wfg_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // controller
  wfg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  wfg_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// tb: self-checking bench for wait_for_graph_cycle_detector_core, a directed table then
// random graph build-and-check sequences; depends on wfg_pkg and the core

module tb;
  import wfg_pkg::*;

  localparam int unsigned NODES_MAX   = MAX_NODES_DEF;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned TAIL_CYCLES = 50;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned DIR_ROWS    = 25;
  localparam int unsigned PHASES      = 12;

  // mode code 3 is not in the enum and must be rejected
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    NODE_FREE,
    NODE_ON_PATH,
    NODE_DONE
  } mark_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_e;

  // directed row: node count in effect, request fields, optional typed-in result
  typedef struct packed {
    logic [CFG_W-1:0]  count;
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic              typed;
    logic              status;
    logic              cycle;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] count;
    idle_e            idle;
    logic [11:0]      items;
    logic             pressure;
  } phase_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  req_t             in_req_i;
  logic             out_valid_o;
  logic             out_stall_i;
  rsp_t             out_rsp_o;

  // predictor state
  logic [63:0]      graph_rows [64];
  logic [CFG_W-1:0] node_count_q;

  rsp_t        verdicts_due [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned send_pct;
  int unsigned recv_pct;
  logic        hold_req;

  dir_row_t dir_rows [DIR_ROWS];
  phase_t   phases [PHASES];

  wait_for_graph_cycle_detector_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // number of nodes the block actually uses
  function automatic int unsigned nodes_live();
    return (node_count_q > NODES_MAX) ? NODES_MAX : int'(node_count_q);
  endfunction

  // depth-first search over live nodes, a back edge to a node on the path is a cycle
  function automatic logic graph_has_cycle(int unsigned n);
    logic [63:0]   live;
    logic [63:0]   succ;
    mark_e         mark [64];
    int unsigned   path_node [64];
    int unsigned   path_next [64];
    int unsigned   depth;
    int unsigned   top;
    int            hit_node;
    logic          found;
    live  = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    found = 1'b0;
    for (int i = 0; i < 64; i++) mark[i] = NODE_FREE;
    for (int unsigned s = 0; s < n && !found; s++) begin
      if (mark[s] == NODE_FREE) begin
        depth        = 1;
        path_node[0] = s;
        path_next[0] = 0;
        mark[s]      = NODE_ON_PATH;
        while (depth > 0 && !found) begin
          top      = depth - 1;
          succ     = graph_rows[path_node[top]] & live;
          hit_node = -1;
          for (int t = 63; t >= 0; t--) begin
            if (succ[t] && t >= int'(path_next[top])) hit_node = t;
          end
          if (hit_node < 0) begin
            mark[path_node[top]] = NODE_DONE;
            depth--;
          end else begin
            path_next[top] = hit_node + 1;
            if (mark[hit_node] == NODE_ON_PATH) begin
              found = 1'b1;
            end else if (mark[hit_node] == NODE_FREE) begin
              mark[hit_node]   = NODE_ON_PATH;
              path_node[depth] = hit_node;
              path_next[depth] = 0;
              depth++;
            end
          end
        end
      end
    end
    return found;
  endfunction

  // expected response for one request, updates the predicted graph
  function automatic rsp_t wfg_verdict(req_t r);
    rsp_t        v;
    int unsigned n;
    n = nodes_live();
    v = '0;
    case (r.mode)
      MODE_ADD: begin
        if (r.from_node < n && r.to_node < n) graph_rows[r.from_node][r.to_node] = 1'b1;
        else v.status = 1'b1;
      end
      MODE_CLEAR: begin
        for (int i = 0; i < 64; i++) graph_rows[i] = '0;
      end
      MODE_CHECK: begin
        v.cycle_found = graph_has_cycle(n);
      end
      default: begin
        v.status = 1'b1;
      end
    endcase
    return v;
  endfunction

  // offer one request, wait for the handshake, then queue its verdict
  task automatic offer(req_t r, logic typed, rsp_t typed_rsp);
    rsp_t v;
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    v = wfg_verdict(r);
    verdicts_due.insert(verdicts_due.size(), typed ? typed_rsp : v);
    items_sent++;
  endtask

  task automatic issue(int unsigned m, int unsigned f, int unsigned t);
    offer('{mode: MODE_W'(m), from_node: NODE_W'(f), to_node: NODE_W'(t)}, 1'b0, '0);
  endtask

  // stop offering and wait until every response is back
  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [CFG_W-1:0] value);
    drain_all();
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    node_count_q = value;
  endtask

  // optional clear, a batch of adds (in range unless no node is in use), then a check
  task automatic build_and_check(int unsigned n);
    int unsigned span;
    int unsigned k;
    int unsigned style;
    int unsigned a;
    int unsigned b;
    int unsigned tmp;
    span  = (n == 0) ? 1 : ((n > 40) ? 40 : n);
    k     = $urandom_range(2 * span + 1, 1);
    style = $urandom_range(2);
    if ($urandom_range(99) < 70) issue(MODE_CLEAR, $urandom_range(63), $urandom_range(63));
    for (int unsigned i = 0; i < k; i++) begin
      if (n == 0) begin
        a = $urandom_range(63);
        b = $urandom_range(63);
      end else begin
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
      end
      // acyclic styles only add edges that go up in node order when more than one node is in use
      if (style != 0 && n > 1) begin
        if (a > b) begin
          tmp = a;
          a   = b;
          b   = tmp;
        end
        if (a == b) begin
          if (b + 1 < n) b = b + 1;
          else a = a - 1;
        end
      end
      issue(MODE_ADD, a, b);
    end
    // one back edge, from a higher to a lower node, that may close a loop
    if (style == 2 && n > 1) begin
      a = $urandom_range(n - 1, 1);
      b = $urandom_range(a - 1);
      issue(MODE_ADD, a, b);
    end
    issue(MODE_CHECK, $urandom_range(63), $urandom_range(63));
  endtask

  // request stimulus
  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    hold_req     = 1'b0;
    recv_pct     = 0;
    send_pct     = 0;
    mismatches   = 0;
    items_sent   = 0;
    node_count_q = NODE_COUNT_RST;
    for (int i = 0; i < 64; i++) graph_rows[i] = '0;

    dir_rows = '{
      '{7'd64,  MODE_CHECK,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
      '{7'd64,  MODE_ADD,    6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
      '{7'd64,  MODE_CHECK,  6'd0,  6'd0,  1'b1, 1'b0, 1'b1},
      '{7'd64,  MODE_CLEAR,  6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
      '{7'd64,  MODE_CHECK,  6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
      '{7'd64,  MODE_ADD,    6'd0,  6'd63, 1'b1, 1'b0, 1'b0},
      '{7'd64,  MODE_ADD,    6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
      '{7'd64,  MODE_ADD,    6'd0,  6'd63, 1'b1, 1'b0, 1'b0},
      '{7'd64,  MODE_CHECK,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
      '{7'd64,  MODE_UNUSED, 6'd63, 6'd63, 1'b1, 1'b1, 1'b0},
      '{7'd64,  MODE_CLEAR,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
      '{7'd3,   MODE_ADD,    6'd3,  6'd0,  1'b1, 1'b1, 1'b0},
      '{7'd3,   MODE_ADD,    6'd0,  6'd3,  1'b1, 1'b1, 1'b0},
      '{7'd3,   MODE_ADD,    6'd0,  6'd1,  1'b0, 1'b0, 1'b0},
      '{7'd3,   MODE_ADD,    6'd1,  6'd2,  1'b0, 1'b0, 1'b0},
      '{7'd3,   MODE_CHECK,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
      '{7'd3,   MODE_ADD,    6'd2,  6'd0,  1'b0, 1'b0, 1'b0},
      '{7'd3,   MODE_CHECK,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
      '{7'd2,   MODE_CHECK,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
      '{7'd0,   MODE_ADD,    6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
      '{7'd0,   MODE_CHECK,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
      '{7'd127, MODE_ADD,    6'd63, 6'd62, 1'b1, 1'b0, 1'b0},
      '{7'd127, MODE_CHECK,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
      '{7'd1,   MODE_ADD,    6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
      '{7'd1,   MODE_CHECK,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0}
    };

    phases = '{
      '{7'd8,   IDLE_NONE, 12'd150, 1'b1},
      '{7'd64,  IDLE_SEND, 12'd60,  1'b0},
      '{7'd5,   IDLE_RECV, 12'd150, 1'b0},
      '{7'd1,   IDLE_BOTH, 12'd80,  1'b0},
      '{7'd16,  IDLE_BOTH, 12'd150, 1'b0},
      '{7'd127, IDLE_NONE, 12'd60,  1'b0},
      '{7'd0,   IDLE_SEND, 12'd40,  1'b0},
      '{7'd3,   IDLE_RECV, 12'd150, 1'b0},
      '{7'd12,  IDLE_NONE, 12'd150, 1'b0},
      '{7'd2,   IDLE_BOTH, 12'd100, 1'b0},
      '{7'd65,  IDLE_RECV, 12'd50,  1'b0},
      '{7'd7,   IDLE_SEND, 12'd110, 1'b0}
    };

    // reset
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].count != node_count_q) write_node_count(dir_rows[i].count);
      offer('{mode: dir_rows[i].mode, from_node: dir_rows[i].src, to_node: dir_rows[i].dst},
            dir_rows[i].typed,
            '{status: dir_rows[i].status, cycle_found: dir_rows[i].cycle});
    end

    // random phases, mostly well-formed build-and-check sequences
    for (int p = 0; p < PHASES; p++) begin
      write_node_count(phases[p].count);
      send_pct = (phases[p].idle == IDLE_SEND) ? 80 : (phases[p].idle == IDLE_BOTH) ? 35 : 0;
      recv_pct <= (phases[p].idle == IDLE_RECV) ? 80 : (phases[p].idle == IDLE_BOTH) ? 35 : 0;
      if (phases[p].pressure) hold_req <= 1'b1;
      items_sent = 0;
      while (items_sent < phases[p].items) begin
        if ($urandom_range(99) < 75) begin
          build_and_check(nodes_live());
        end else begin
          issue($urandom_range(3), $urandom_range(63), $urandom_range(63));
        end
      end
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // response side stalls, with one long hold-off when asked
  initial begin : recv_stalls
    int unsigned hold_left;
    logic        hold_used;
    hold_left   = 0;
    hold_used   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_used) begin
        hold_used = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_pct);
      end
    end
  end

  // compare each accepted response with the oldest verdict
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected response: status %0d cycle %0d", out_rsp_o.status,
                   out_rsp_o.cycle_found);
      end else begin
        want = verdicts_due.pop_front();
        if (out_rsp_o.status !== want.status || out_rsp_o.cycle_found !== want.cycle_found)
        begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("response mismatch: expected status %0d cycle %0d, got status %0d cycle %0d",
                     want.status, want.cycle_found, out_rsp_o.status, out_rsp_o.cycle_found);
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
